// ===== design/vfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vfa_pkg
// command codes, fixed sizes and saturation helper for the vector alu core
// ----------------------------------------------------------------------------
package vfa_pkg;

    localparam logic [3:0] CMD_ADDV = 4'd0;
    localparam logic [3:0] CMD_SUBV = 4'd1;
    localparam logic [3:0] CMD_ADDS = 4'd2;
    localparam logic [3:0] CMD_SUBS = 4'd3;
    localparam logic [3:0] CMD_MULS = 4'd4;
    localparam logic [3:0] CMD_DIVS = 4'd5;
    localparam logic [3:0] CMD_NEG  = 4'd6;
    localparam logic [3:0] CMD_DOT  = 4'd7;
    localparam logic [3:0] CMD_NORM = 4'd8;
    localparam logic [3:0] CMD_MAX  = 4'd9;
    localparam logic [3:0] CMD_MIN  = 4'd10;
    localparam logic [3:0] CMD_EQ   = 4'd11;

    localparam int SQ_STAGES = 32;

    function automatic logic signed [63:0] sat_to(input logic signed [64:0] v,
                                                  input int unsigned cw);
        logic signed [64:0] hi;
        logic signed [64:0] lo;
        hi = (65'sd1 <<< (cw - 1)) - 65'sd1;
        lo = -hi - 65'sd1;
        if (v > hi)
        begin
            return hi[63:0];
        end
        else if (v < lo)
        begin
            return lo[63:0];
        end
        return v[63:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/vfa_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vfa_lane
// one component lane: elementwise ops, scalar multiply, square and product
// ----------------------------------------------------------------------------
module vfa_lane
    import vfa_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int COMP_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic [3:0]                   cmd,
    input  logic signed [31:0]           a,
    input  logic signed [31:0]           b,
    input  logic signed [31:0]           s,
    output logic signed [COMP_WIDTH-1:0] r_pre,
    output logic [63:0]                  sq_a,
    output logic signed [63:0]           prod_ab,
    output logic                         eq
);

    logic signed [64:0] a_w;
    logic signed [64:0] b_w;
    logic signed [64:0] s_w;
    logic signed [64:0] simple_v;
    logic signed [63:0] simple_sat;
    logic signed [63:0] mul_as;
    logic signed [63:0] mul_sh;
    logic signed [63:0] mul_sat;

    logic [3:0]                   cmd1_reg;
    logic signed [COMP_WIDTH-1:0] simple1_reg;
    logic signed [63:0]           prod_as1_reg;
    logic [63:0]                  sq1_reg;
    logic signed [63:0]           ab1_reg;
    logic                         eq1_reg;

    logic signed [COMP_WIDTH-1:0] r2_reg;
    logic [63:0]                  sq2_reg;
    logic signed [63:0]           ab2_reg;
    logic                         eq2_reg;

    always_comb
    begin
        a_w = 65'(a);
        b_w = 65'(b);
        s_w = 65'(s);
        unique case (cmd)
            CMD_ADDV: simple_v = a_w + b_w;
            CMD_SUBV: simple_v = a_w - b_w;
            CMD_ADDS: simple_v = a_w + s_w;
            CMD_SUBS: simple_v = a_w - s_w;
            CMD_NEG:  simple_v = -a_w;
            CMD_MAX:  simple_v = (a_w < b_w) ? b_w : a_w;
            CMD_MIN:  simple_v = (a_w > b_w) ? b_w : a_w;
            default:  simple_v = a_w;
        endcase
    end

    assign simple_sat = sat_to(simple_v, COMP_WIDTH);
    assign mul_as     = a * s;

    always_ff @(posedge clk)
    begin
        cmd1_reg     <= cmd;
        simple1_reg  <= simple_sat[COMP_WIDTH-1:0];
        prod_as1_reg <= mul_as;
        sq1_reg      <= a * a;
        ab1_reg      <= a * b;
        eq1_reg      <= (a == b);
    end

    // arithmetic shift floors toward minus infinity
    assign mul_sh  = prod_as1_reg >>> FRAC_BITS;
    assign mul_sat = sat_to(65'(mul_sh), COMP_WIDTH);

    always_ff @(posedge clk)
    begin
        r2_reg  <= (cmd1_reg == CMD_MULS) ? mul_sat[COMP_WIDTH-1:0] : simple1_reg;
        sq2_reg <= sq1_reg;
        ab2_reg <= ab1_reg;
        eq2_reg <= eq1_reg;
    end

    assign r_pre   = r2_reg;
    assign sq_a    = sq2_reg;
    assign prod_ab = ab2_reg;
    assign eq      = eq2_reg;

endmodule
`default_nettype wire

// ===== design/vfa_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vfa_sqrt
// pipelined integer square root, one root bit per stage, with sideband
// ----------------------------------------------------------------------------
module vfa_sqrt
    import vfa_pkg::*;
#(
    parameter int SB_W = 1
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [63:0]     in_value,
    input  logic [SB_W-1:0] in_sb,
    output logic            out_valid,
    output logic [31:0]     out_root,
    output logic [SB_W-1:0] out_sb
);

    logic            vld_reg  [SQ_STAGES];
    logic [63:0]     val_reg  [SQ_STAGES];
    logic [33:0]     rem_reg  [SQ_STAGES];
    logic [31:0]     root_reg [SQ_STAGES];
    logic [SB_W-1:0] sb_reg   [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_stage
        logic            vld_in;
        logic [63:0]     val_in;
        logic [33:0]     rem_in;
        logic [31:0]     root_in;
        logic [SB_W-1:0] sb_in;
        logic [33:0]     rem_sh;
        logic [33:0]     trial;
        logic            ge;

        if (k == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign val_in  = in_value;
            assign rem_in  = '0;
            assign root_in = '0;
            assign sb_in   = in_sb;
        end
        else
        begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign val_in  = val_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign sb_in   = sb_reg[k-1];
        end

        assign rem_sh = {rem_in[31:0], val_in[63:62]};
        assign trial  = {root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            val_reg[k]  <= {val_in[61:0], 2'b00};
            rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg[k] <= {root_in[30:0], ge};
            sb_reg[k]   <= sb_in;
        end
    end

    assign out_valid = vld_reg[SQ_STAGES-1];
    assign out_root  = root_reg[SQ_STAGES-1];
    assign out_sb    = sb_reg[SQ_STAGES-1];

endmodule
`default_nettype wire

// ===== design/vfa_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vfa_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module vfa_div
#(
    parameter int NUM_W = 48,
    parameter int SB_W  = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [31:0]      in_den,
    input  logic [SB_W-1:0]  in_sb,
    output logic             out_valid,
    output logic [NUM_W-1:0] out_quo,
    output logic [SB_W-1:0]  out_sb
);

    logic             vld_reg [NUM_W];
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [31:0]      den_reg [NUM_W];
    logic [31:0]      rem_reg [NUM_W];
    logic [NUM_W-1:0] quo_reg [NUM_W];
    logic [SB_W-1:0]  sb_reg  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic             vld_in;
        logic [NUM_W-1:0] num_in;
        logic [31:0]      den_in;
        logic [31:0]      rem_in;
        logic [NUM_W-1:0] quo_in;
        logic [SB_W-1:0]  sb_in;
        logic [32:0]      rem_sh;
        logic [32:0]      diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign vld_in = in_valid;
            assign num_in = in_num;
            assign den_in = in_den;
            assign rem_in = '0;
            assign quo_in = '0;
            assign sb_in  = in_sb;
        end
        else
        begin : g_next
            assign vld_in = vld_reg[k-1];
            assign num_in = num_reg[k-1];
            assign den_in = den_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign sb_in  = sb_reg[k-1];
        end

        assign rem_sh = {rem_in, num_in[NUM_W-1]};
        assign diff   = rem_sh - {1'b0, den_in};
        assign ge     = (rem_sh >= {1'b0, den_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            num_reg[k] <= {num_in[NUM_W-2:0], 1'b0};
            den_reg[k] <= den_in;
            rem_reg[k] <= ge ? diff[31:0] : rem_sh[31:0];
            quo_reg[k] <= {quo_in[NUM_W-2:0], ge};
            sb_reg[k]  <= sb_in;
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign out_quo   = quo_reg[NUM_W-1];
    assign out_sb    = sb_reg[NUM_W-1];

endmodule
`default_nettype wire

// ===== design/vector3_fixed_point_alu_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu_core
// three-lane signed fixed-point vector alu with norm, magnitude and dot product
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is taken every cycle and busy stays low.
// Each result is strobed by done for exactly one cycle; the receiver cannot
// stall it, so it must take every result as it comes. Latency is set by the
// two 32-stage square-root pipelines (magnitude of A for normalize, then the
// result magnitude) and the 32 + FRAC_BITS stage dividers used by scalar
// divide and normalize, one per component, one bit per stage in each.
// ----------------------------------------------------------------------------
module vector3_fixed_point_alu_core
    import vfa_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int COMP_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         command,
    input  logic signed [31:0] ax,
    input  logic signed [31:0] ay,
    input  logic signed [31:0] az,
    input  logic signed [31:0] bx,
    input  logic signed [31:0] by,
    input  logic signed [31:0] bz,
    input  logic signed [31:0] scalar_in,
    output logic               done,
    output logic signed [31:0] rx,
    output logic signed [31:0] ry,
    output logic signed [31:0] rz,
    output logic [63:0]        norm_squared,
    output logic [31:0]        magnitude,
    output logic signed [63:0] dot_value,
    output logic               equal_flag,
    output logic               divide_fault
);

    localparam int CW     = COMP_WIDTH;
    localparam int NUM_W  = 32 + FRAC_BITS;
    localparam int SB1_W  = 4 + 96 + 32 + 3 * CW + 64 + 1;
    localparam int SH_W   = 4 + 1 + 1 + 64 + 1 + 96 + 3 * CW;
    localparam int SB2_W  = 3 * CW + 64 + 64 + 2;
    localparam int LAT    = 72 + NUM_W;

    logic               accept;
    logic [2:0][31:0]   in_a;
    logic [2:0][31:0]   in_b;

    logic [2:0][CW-1:0] lane_r;
    logic [2:0][63:0]   lane_sq;
    logic [2:0][63:0]   lane_ab;
    logic [2:0]         lane_eq;

    logic               v1_reg;
    logic               v2_reg;
    logic [3:0]         cmd1_reg;
    logic [3:0]         cmd2_reg;
    logic [2:0][31:0]   a1_reg;
    logic [2:0][31:0]   a2_reg;
    logic [31:0]        s1_reg;
    logic [31:0]        s2_reg;

    logic               v3_reg;
    logic [3:0]         cmd3_reg;
    logic [2:0][31:0]   a3_reg;
    logic [31:0]        s3_reg;
    logic [2:0][CW-1:0] r3_reg;
    logic [63:0]        na3_reg;
    logic [63:0]        dot1_3_reg;
    logic [63:0]        p2_3_reg;
    logic               eq3_reg;
    logic signed [63:0] dot1_next;

    logic               v4_reg;
    logic [3:0]         cmd4_reg;
    logic [2:0][31:0]   a4_reg;
    logic [31:0]        s4_reg;
    logic [2:0][CW-1:0] r4_reg;
    logic [63:0]        na4_reg;
    logic [63:0]        dot4_reg;
    logic               eq4_reg;
    logic signed [63:0] dot_next;

    logic               sq1_valid;
    logic [31:0]        am;
    logic [SB1_W-1:0]   sq1_sb;
    logic [3:0]         u_cmd;
    logic [2:0][31:0]   u_a;
    logic [31:0]        u_s;
    logic [2:0][CW-1:0] u_r;
    logic [63:0]        u_dot;
    logic               u_eq;

    logic [2:0][NUM_W-1:0] div_num;
    logic [2:0][31:0]      div_den;
    logic [2:0]            div_neg;
    logic [SH_W-1:0]       shared;

    logic                  d_valid;
    logic [2:0][NUM_W-1:0] d_quo;
    logic [SH_W:0]         d_sb0;
    logic [2:0]            d_neg;
    logic [3:0]            d_cmd;
    logic                  d_szero;
    logic                  d_amnz;
    logic [63:0]           d_dot;
    logic                  d_eq;
    logic [2:0][31:0]      d_a;
    logic [2:0][CW-1:0]    d_r;
    logic [2:0][CW-1:0]    r6_next;

    logic               v6_reg;
    logic [2:0][CW-1:0] r6_reg;
    logic [63:0]        dot6_reg;
    logic               eq6_reg;
    logic               fault6_reg;

    logic               v7_reg;
    logic [2:0][CW-1:0] r7_reg;
    logic [2:0][63:0]   sq7_reg;
    logic [63:0]        dot7_reg;
    logic               eq7_reg;
    logic               fault7_reg;

    logic               v8_reg;
    logic [2:0][CW-1:0] r8_reg;
    logic [63:0]        n2_8_reg;
    logic [63:0]        dot8_reg;
    logic               eq8_reg;
    logic               fault8_reg;

    logic               sq2_valid;
    logic [31:0]        mag;
    logic [SB2_W-1:0]   sq2_sb;

    logic               done_reg;
    logic [2:0][CW-1:0] out_r_reg;
    logic [63:0]        out_n2_reg;
    logic [31:0]        out_mag_reg;
    logic [63:0]        out_dot_reg;
    logic               out_eq_reg;
    logic               out_fault_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign in_a   = {az, ay, ax};
    assign in_b   = {bz, by, bx};

    // component lanes
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        vfa_lane #(
            .FRAC_BITS  (FRAC_BITS),
            .COMP_WIDTH (COMP_WIDTH)
        ) u_lane (
            .clk     (clk),
            .cmd     (command),
            .a       ($signed(in_a[i])),
            .b       ($signed(in_b[i])),
            .s       (scalar_in),
            .r_pre   (lane_r[i]),
            .sq_a    (lane_sq[i]),
            .prod_ab (lane_ab[i]),
            .eq      (lane_eq[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v8_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v6_reg   <= d_valid;
            v7_reg   <= v6_reg;
            v8_reg   <= v7_reg;
            done_reg <= sq2_valid;
        end
    end

    // merge of lane results
    assign dot1_next = sat_to(65'($signed(lane_ab[0])) + 65'($signed(lane_ab[1])), 64);
    assign dot_next  = sat_to(65'($signed(dot1_3_reg)) + 65'($signed(p2_3_reg)), 64);

    always_ff @(posedge clk)
    begin
        cmd1_reg   <= command;
        a1_reg     <= in_a;
        s1_reg     <= scalar_in;
        cmd2_reg   <= cmd1_reg;
        a2_reg     <= a1_reg;
        s2_reg     <= s1_reg;

        cmd3_reg   <= cmd2_reg;
        a3_reg     <= a2_reg;
        s3_reg     <= s2_reg;
        r3_reg     <= lane_r;
        na3_reg    <= lane_sq[0] + lane_sq[1] + lane_sq[2];
        dot1_3_reg <= dot1_next;
        p2_3_reg   <= lane_ab[2];
        eq3_reg    <= &lane_eq;

        cmd4_reg   <= cmd3_reg;
        a4_reg     <= a3_reg;
        s4_reg     <= s3_reg;
        r4_reg     <= r3_reg;
        na4_reg    <= na3_reg;
        dot4_reg   <= dot_next;
        eq4_reg    <= eq3_reg;
    end

    // magnitude of a for normalize
    vfa_sqrt #(
        .SB_W (SB1_W)
    ) u_sqrt_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_value  (na4_reg),
        .in_sb     ({cmd4_reg, a4_reg, s4_reg, r4_reg, dot4_reg, eq4_reg}),
        .out_valid (sq1_valid),
        .out_root  (am),
        .out_sb    (sq1_sb)
    );

    assign {u_cmd, u_a, u_s, u_r, u_dot, u_eq} = sq1_sb;

    for (genvar i = 0; i < 3; i++)
    begin : g_div_in
        logic [31:0] abs_a;
        logic [31:0] abs_s;
        assign abs_a      = u_a[i][31] ? (32'd0 - u_a[i]) : u_a[i];
        assign abs_s      = u_s[31] ? (32'd0 - u_s) : u_s;
        assign div_num[i] = {abs_a, {FRAC_BITS{1'b0}}};
        assign div_den[i] = (u_cmd == CMD_NORM) ? am : abs_s;
        assign div_neg[i] = u_a[i][31] ^ ((u_cmd != CMD_NORM) && u_s[31]);
    end

    assign shared = {u_cmd, (u_s == 32'd0), (am != 32'd0), u_dot, u_eq, u_a, u_r};

    vfa_div #(
        .NUM_W (NUM_W),
        .SB_W  (SH_W + 1)
    ) u_div0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq1_valid),
        .in_num    (div_num[0]),
        .in_den    (div_den[0]),
        .in_sb     ({div_neg[0], shared}),
        .out_valid (d_valid),
        .out_quo   (d_quo[0]),
        .out_sb    (d_sb0)
    );

    vfa_div #(
        .NUM_W (NUM_W),
        .SB_W  (1)
    ) u_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq1_valid),
        .in_num    (div_num[1]),
        .in_den    (div_den[1]),
        .in_sb     (div_neg[1]),
        .out_valid (),
        .out_quo   (d_quo[1]),
        .out_sb    (d_neg[1])
    );

    vfa_div #(
        .NUM_W (NUM_W),
        .SB_W  (1)
    ) u_div2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq1_valid),
        .in_num    (div_num[2]),
        .in_den    (div_den[2]),
        .in_sb     (div_neg[2]),
        .out_valid (),
        .out_quo   (d_quo[2]),
        .out_sb    (d_neg[2])
    );

    assign {d_neg[0], d_cmd, d_szero, d_amnz, d_dot, d_eq, d_a, d_r} = d_sb0;

    // final component select
    for (genvar i = 0; i < 3; i++)
    begin : g_sel
        logic signed [NUM_W:0] q_mag;
        logic signed [NUM_W:0] q_sgn;
        logic signed [63:0]    div_sat;
        logic signed [63:0]    pass_sat;
        logic signed [63:0]    hi_sat;
        logic signed [63:0]    lo_sat;
        logic signed [31:0]    a_s;
        logic [CW-1:0]         zdv;

        assign a_s      = $signed(d_a[i]);
        assign q_mag    = $signed({1'b0, d_quo[i]});
        assign q_sgn    = d_neg[i] ? -q_mag : q_mag;
        assign div_sat  = sat_to(65'(q_sgn), CW);
        assign pass_sat = sat_to(65'(a_s), CW);
        assign hi_sat   = sat_to({2'b00, {63{1'b1}}}, CW);
        assign lo_sat   = sat_to({2'b11, {63{1'b0}}}, CW);
        assign zdv      = (a_s > 0) ? hi_sat[CW-1:0]
                        : ((a_s < 0) ? lo_sat[CW-1:0] : '0);

        always_comb
        begin
            unique case (d_cmd)
                CMD_DIVS: r6_next[i] = d_szero ? zdv : div_sat[CW-1:0];
                CMD_NORM: r6_next[i] = d_amnz ? div_sat[CW-1:0] : pass_sat[CW-1:0];
                default:  r6_next[i] = d_r[i];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        r6_reg     <= r6_next;
        dot6_reg   <= d_dot;
        eq6_reg    <= d_eq;
        fault6_reg <= (d_cmd == CMD_DIVS) && d_szero;

        r7_reg     <= r6_reg;
        dot7_reg   <= dot6_reg;
        eq7_reg    <= eq6_reg;
        fault7_reg <= fault6_reg;

        r8_reg     <= r7_reg;
        n2_8_reg   <= sq7_reg[0] + sq7_reg[1] + sq7_reg[2];
        dot8_reg   <= dot7_reg;
        eq8_reg    <= eq7_reg;
        fault8_reg <= fault7_reg;
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_sq
        always_ff @(posedge clk)
        begin
            sq7_reg[i] <= 64'($signed(r6_reg[i]) * $signed(r6_reg[i]));
        end
    end

    // magnitude of the result
    vfa_sqrt #(
        .SB_W (SB2_W)
    ) u_sqrt_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v8_reg),
        .in_value  (n2_8_reg),
        .in_sb     ({r8_reg, n2_8_reg, dot8_reg, eq8_reg, fault8_reg}),
        .out_valid (sq2_valid),
        .out_root  (mag),
        .out_sb    (sq2_sb)
    );

    always_ff @(posedge clk)
    begin
        {out_r_reg, out_n2_reg, out_dot_reg, out_eq_reg, out_fault_reg} <= sq2_sb;
        out_mag_reg <= mag;
    end

    assign done         = done_reg;
    assign rx           = 32'($signed(out_r_reg[0]));
    assign ry           = 32'($signed(out_r_reg[1]));
    assign rz           = 32'($signed(out_r_reg[2]));
    assign norm_squared = out_n2_reg;
    assign magnitude    = out_mag_reg;
    assign dot_value    = out_dot_reg;
    assign equal_flag   = out_eq_reg;
    assign divide_fault = out_fault_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("transaction result missing at expected latency");

    a_root_low: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (64'(magnitude) * 64'(magnitude) <= norm_squared))
        else $error("magnitude too large");

    a_root_high: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((66'(magnitude) + 66'd1) * (66'(magnitude) + 66'd1)
                  > 66'(norm_squared)))
        else $error("magnitude too small");

    a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (done && norm_squared == 64'd0) |-> (rx == 32'sd0 && ry == 32'sd0 && rz == 32'sd0))
        else $error("zero norm with nonzero result vector");

endmodule
`default_nettype wire
